// ----- hw/rtl/rtps_sd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rtps_sd_pkg;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR     = 5'b00001,
    PH_SUBHDR  = 5'b00010,
    PH_DST     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SKIP    = 5'b10000
  } phase_e;

  // Register indexes on the config port
  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_PREFIX_HIGH = 2'd1,
    REG_PREFIX_LOW  = 2'd2
  } reg_idx_e;

  localparam int unsigned CfgDataW = 64;

  localparam logic [15:0] HdrBytes    = 16'd20;
  localparam logic [15:0] PrefixAt    = 16'd8;
  localparam logic [15:0] PrefixBytes = 16'd12;
  localparam logic [15:0] MagicBytes  = 16'd4;
  localparam logic [15:0] OffsetMax   = 16'hffff;

  localparam logic [7:0] IdHeartbeat = 8'h07;
  localparam logic [7:0] IdData      = 8'h15;
  localparam logic [7:0] IdInfoDst   = 8'h0e;

  // 'R','T','P','S': element 0 is the first byte on the wire
  localparam logic [3:0][7:0] Magic = {8'h53, 8'h50, 8'h54, 8'h52};

endpackage

`default_nettype wire

// ----- hw/rtl/rtps_sd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Packet byte stream into the demux
interface rtps_sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// Flagged byte stream out of the demux
interface rtps_sd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       packet_last;
  logic       sub_last;
  logic       guid_valid;
  logic       heartbeat_valid;
  logic       user_data_valid;

  modport source (output valid, output byte_out, output packet_last, output sub_last,
                  output guid_valid, output heartbeat_valid, output user_data_valid,
                  input ready);
  modport sink   (input valid, input byte_out, input packet_last, input sub_last,
                  input guid_valid, input heartbeat_valid, input user_data_valid,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rtps_submessage_demux.sv -----
// RTPS submessage demux.
// rx_i carries packet bytes, one item per byte, with last on the final byte.
// tx_o returns every byte unchanged with flags: guid_valid on header bytes
// 8..19, heartbeat_valid / user_data_valid on the header and payload bytes of
// HEARTBEAT and DATA submessages, sub_last on the final payload byte of a
// submessage other than INFO_DST or on the packet's last byte. An INFO_DST
// whose leading prefix bytes differ from the own prefix, or a bad 'RTPS'
// magic, sends the rest of the packet through unflagged.
// A byte accepted at an edge is held in the result register and appears on
// tx_o in the following cycle. One byte per cycle is taken while tx_o keeps
// ready; the parser state and the result register both update at the accepting edge.
// If the receiver stalls, the result register holds; rx_i.ready stays high
// while the register is empty or being drained, so there is no bubble.
// Reset clears enable, the prefix and the parser (header phase, offset 0) and
// empties the result register. cfg_* writes are registered; the user must
// make them while the stream is idle, as the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module rtps_submessage_demux
  import rtps_sd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  rtps_sd_in_if.sink               rx_i,
  rtps_sd_out_if.source            tx_o
);

  // Config registers
  logic        enable_q;
  logic [63:0] prefix_high_q;
  logic [31:0] prefix_low_q;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [15:0] off_q, off_d;
  logic [7:0]  id_q, id_d;
  logic        le_q, le_d;
  logic [15:0] len_q, len_d;

  // Result register
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       pkt_last_q, sub_last_q, gv_q, hv_q, uv_q;

  logic       accept;
  logic       sub_end, gv, hv, uv;
  logic [7:0] d;
  logic       last;

  // Own prefix, byte 0 in element 11
  logic [11:0][7:0] own_bytes;
  logic [3:0]       own_idx;
  logic [7:0]       own_byte;

  assign d    = rx_i.data_byte;
  assign last = rx_i.last;

  // Result register frees up when empty or being taken this cycle
  assign rx_i.ready = !out_valid_q || tx_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  assign own_bytes = {prefix_high_q, prefix_low_q};
  assign own_idx   = 4'd11 - off_q[3:0];
  assign own_byte  = own_bytes[own_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      prefix_high_q <= '0;
      prefix_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:      enable_q      <= cfg_data_i[0];
        REG_PREFIX_HIGH: prefix_high_q <= cfg_data_i;
        REG_PREFIX_LOW:  prefix_low_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Next parser state and flags for the byte on rx_i
  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    id_d    = id_q;
    le_d    = le_q;
    len_d   = len_q;
    sub_end = last;
    gv      = 1'b0;
    hv      = 1'b0;
    uv      = 1'b0;

    case (phase_q)
      PH_HDR: begin
        if (off_q < MagicBytes && d != Magic[off_q[1:0]]) begin
          phase_d = PH_SKIP;
        end else begin
          gv    = (off_q >= PrefixAt) && (off_q < PrefixAt + PrefixBytes);
          off_d = off_q + 16'd1;
          if (off_d >= HdrBytes) begin
            off_d   = '0;
            phase_d = enable_q ? PH_SUBHDR : PH_SKIP;
          end
        end
      end
      PH_SUBHDR: begin
        // id, flags, then the 16-bit length in the order flags bit 0 gives
        case (off_q[1:0])
          2'd0: id_d = d;
          2'd1: le_d = d[0];
          2'd2: len_d = le_q ? {8'h00, d} : {d, 8'h00};
          default: len_d = len_q | (le_q ? {d, 8'h00} : {8'h00, d});
        endcase
        hv    = (id_d == IdHeartbeat);
        uv    = (id_d == IdData);
        off_d = off_q + 16'd1;
        if (off_q[1:0] == 2'd3) begin
          off_d   = '0;
          phase_d = (id_q == IdInfoDst) ? PH_DST : PH_PAYLOAD;
        end
      end
      PH_DST: begin
        if (off_q < PrefixBytes && d != own_byte) begin
          phase_d = PH_SKIP;
        end else begin
          if (off_q != OffsetMax) off_d = off_q + 16'd1;
          if (len_q != '0 && off_d == len_q) begin
            off_d   = '0;
            phase_d = PH_SUBHDR;
          end
        end
      end
      PH_PAYLOAD: begin
        hv = (id_q == IdHeartbeat);
        uv = (id_q == IdData);
        if (off_q != OffsetMax) off_d = off_q + 16'd1;
        // zero length runs to the end of the packet
        if (len_q != '0 && off_d == len_q) begin
          off_d   = '0;
          phase_d = PH_SUBHDR;
          sub_end = 1'b1;
        end
      end
      PH_SKIP: ;
      default: ;
    endcase

    if (last) begin
      phase_d = PH_HDR;
      off_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      off_q   <= '0;
      id_q    <= '0;
      le_q    <= 1'b0;
      len_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      id_q    <= id_d;
      le_q    <= le_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (tx_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q     <= d;
      pkt_last_q <= last;
      sub_last_q <= sub_end;
      gv_q       <= gv;
      hv_q       <= hv;
      uv_q       <= uv;
    end
  end

  assign tx_o.valid           = out_valid_q;
  assign tx_o.byte_out        = byte_q;
  assign tx_o.packet_last     = pkt_last_q;
  assign tx_o.sub_last        = sub_last_q;
  assign tx_o.guid_valid      = gv_q;
  assign tx_o.heartbeat_valid = hv_q;
  assign tx_o.user_data_valid = uv_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rtps_sd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rtps_sd_assert (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_pkt_last_i,
  input wire logic       out_sub_last_i,
  input wire logic       out_gv_i,
  input wire logic       out_hv_i,
  input wire logic       out_uv_i
);

  // An accepted byte shows up on the output the next cycle
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted byte did not reach the output");

  // Empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i))
    else $error("stalled output changed");

  // A byte belongs to at most one field
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({out_gv_i, out_hv_i, out_uv_i}))
    else $error("more than one valid flag");

  // Packet end always closes the submessage
  a_last_closes_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_pkt_last_i |-> out_sub_last_i)
    else $error("packet_last without sub_last");

endmodule

bind rtps_submessage_demux rtps_sd_assert u_rtps_sd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (rx_i.valid),
  .in_ready_i     (rx_i.ready),
  .out_valid_i    (tx_o.valid),
  .out_ready_i    (tx_o.ready),
  .out_byte_i     (tx_o.byte_out),
  .out_pkt_last_i (tx_o.packet_last),
  .out_sub_last_i (tx_o.sub_last),
  .out_gv_i       (tx_o.guid_valid),
  .out_hv_i       (tx_o.heartbeat_valid),
  .out_uv_i       (tx_o.user_data_valid)
);

`default_nettype wire

// ----- test/rtps_sd_checker.sv -----
`timescale 1ns / 1ps

// Watches both byte streams of the demux, predicts the flags of every
// accepted byte and compares them with what leaves the block.
module rtps_sd_checker
  import rtps_sd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rtps_sd_in_if               rx_mon_i,
  rtps_sd_out_if              tx_mon_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_cnt_o
);

  localparam logic [15:0] SubHdrBytes = 16'd4;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       packet_last;
    logic       sub_last;
    logic       guid_valid;
    logic       heartbeat_valid;
    logic       user_data_valid;
  } flagged_byte_t;

  // predictor state and register copies
  logic          en;
  logic [95:0]   dst_prefix;
  phase_e        ph;
  logic [15:0]   offs;
  logic [7:0]    cur_id;
  logic          le_flag;
  logic [15:0]   cur_len;
  flagged_byte_t flagged_q[$];

  function automatic flagged_byte_t demux_byte(input logic [7:0] d, input logic lst);
    flagged_byte_t r;
    r = '0;
    r.byte_out    = d;
    r.packet_last = lst;
    r.sub_last    = lst;
    case (ph)
      PH_HDR: begin
        if (offs < MagicBytes && d != Magic[offs[1:0]]) begin
          ph = PH_SKIP;
        end else begin
          r.guid_valid = (offs >= PrefixAt) && (offs < PrefixAt + PrefixBytes);
          offs++;
          if (offs >= HdrBytes) begin
            offs = '0;
            ph   = en ? PH_SUBHDR : PH_SKIP;
          end
        end
      end
      PH_SUBHDR: begin
        case (offs)
          16'd0: cur_id = d;
          16'd1: le_flag = d[0];
          16'd2: cur_len = le_flag ? {8'h00, d} : {d, 8'h00};
          default: cur_len = cur_len | (le_flag ? {d, 8'h00} : {8'h00, d});
        endcase
        r.heartbeat_valid = (cur_id == IdHeartbeat);
        r.user_data_valid = (cur_id == IdData);
        offs++;
        if (offs >= SubHdrBytes) begin
          offs = '0;
          ph   = (cur_id == IdInfoDst) ? PH_DST : PH_PAYLOAD;
        end
      end
      PH_DST: begin
        // leading bytes must equal our own prefix, byte 0 first
        if (offs < PrefixBytes && d != dst_prefix[95 - 8 * int'(offs) -: 8]) begin
          ph = PH_SKIP;
        end else begin
          if (offs < OffsetMax) offs++;
          if (cur_len != '0 && offs == cur_len) begin
            offs = '0;
            ph   = PH_SUBHDR;
          end
        end
      end
      PH_PAYLOAD: begin
        r.heartbeat_valid = (cur_id == IdHeartbeat);
        r.user_data_valid = (cur_id == IdData);
        if (offs < OffsetMax) offs++;
        if (cur_len != '0 && offs == cur_len) begin
          offs       = '0;
          ph         = PH_SUBHDR;
          r.sub_last = 1'b1;
        end
      end
      default: ;
    endcase
    if (lst) begin
      ph   = PH_HDR;
      offs = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    flagged_byte_t exp_b, got_b;
    if (!rst_ni) begin
      en         = 1'b0;
      dst_prefix = '0;
      ph         = PH_HDR;
      offs       = '0;
      cur_id     = '0;
      le_flag    = 1'b0;
      cur_len    = '0;
      flagged_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_ENABLE:      en = cfg_data_i[0];
          REG_PREFIX_HIGH: dst_prefix[95:32] = cfg_data_i[63:0];
          REG_PREFIX_LOW:  dst_prefix[31:0] = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (rx_mon_i.valid && rx_mon_i.ready)
        flagged_q.push_back(demux_byte(rx_mon_i.data_byte, rx_mon_i.last));
      if (tx_mon_i.valid && tx_mon_i.ready) begin
        got_b = '{tx_mon_i.byte_out, tx_mon_i.packet_last, tx_mon_i.sub_last,
                  tx_mon_i.guid_valid, tx_mon_i.heartbeat_valid,
                  tx_mon_i.user_data_valid};
        if (flagged_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: unexpected output byte %02h", $realtime, got_b.byte_out);
        end else begin
          exp_b = flagged_q.pop_front();
          if (got_b !== exp_b) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("%0t: mismatch exp byte %02h last %b sub %b guid %b hb %b data %b, got byte %02h last %b sub %b guid %b hb %b data %b",
                       $realtime, exp_b.byte_out, exp_b.packet_last, exp_b.sub_last,
                       exp_b.guid_valid, exp_b.heartbeat_valid, exp_b.user_data_valid,
                       got_b.byte_out, got_b.packet_last, got_b.sub_last,
                       got_b.guid_valid, got_b.heartbeat_valid, got_b.user_data_valid);
          end
        end
      end
    end
    pending_cnt_o = flagged_q.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

// Drives packets through the RTPS demux and gives the verdict; prediction and
// comparison live in rtps_sd_checker.
module testbench;
  import rtps_sd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 210;
  localparam int unsigned NumSettings = 5;
  localparam int unsigned HoldAt      = 300;  // item count at which the sink holds off
  localparam int unsigned HoldCycles  = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int unsigned         fail_cnt;
  int unsigned         pending_cnt;

  rtps_sd_in_if  rx_if ();
  rtps_sd_out_if tx_if ();

  rtps_submessage_demux uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .tx_o       (tx_if)
  );

  rtps_sd_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .rx_mon_i      (rx_if),
    .tx_mon_i      (tx_if),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt)
  );

  // Own GUID prefix as currently programmed, byte 0 in the top bits.
  logic [95:0] own_prefix;
  // Bytes of the packet being sent; last goes on the final one.
  logic [7:0]  pkt_bytes[$];
  int unsigned phase_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a stuck handshake or a lost item ends here.
  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Sink: random stall per item, bursts with no stall, and one long hold-off
  // so that the result register fills and rx ready drops.
  initial begin
    int unsigned got;
    int unsigned stall;
    bit          burst;
    got   = 0;
    burst = 1'b0;
    tx_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (got % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (got == HoldAt) stall = HoldCycles;
      else stall = burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        tx_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      tx_if.ready <= 1'b1;
      do @(posedge clk_i); while (!tx_if.valid);
      got++;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // One item on rx; valid is only lowered when a gap is drawn, so back-to-back
  // items never see valid dropped and raised in the same step.
  task automatic send_byte(input logic [7:0] d, input logic lst, input bit burst);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid     <= 1'b1;
    rx_if.data_byte <= d;
    rx_if.last      <= lst;
    do @(posedge clk_i); while (!rx_if.ready);
  endtask

  task automatic send_packet();
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, burst);
      phase_items++;
    end
  endtask

  // Mostly well-formed packets with random submessages; some bad magic,
  // some truncated, some pure noise.
  task automatic make_packet();
    int unsigned kind, n_sub, r, len, cnt, bad_at, cut;
    bit          big, bad_dst;
    logic [7:0]  id, flags, b;
    pkt_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (int i = 0; i < 4; i++) pkt_bytes.push_back(Magic[i]);
    if (kind < 12)
      pkt_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    repeat (16) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    n_sub = $urandom_range(0, 4);
    for (int s = 0; s < n_sub; s++) begin
      r = $urandom_range(0, 9);
      if (r < 3) id = IdHeartbeat;
      else if (r < 6) id = IdData;
      else if (r < 8) id = IdInfoDst;
      else id = 8'($urandom_range(0, 255));
      flags   = 8'($urandom_range(0, 255));
      len     = (id == IdInfoDst) ? $urandom_range(1, 16) : $urandom_range(1, 12);
      big     = ($urandom_range(0, 19) == 0);
      if (big) len = $urandom_range(13, 65535);
      else if (s == n_sub - 1 && $urandom_range(0, 3) == 0) len = 0;
      bad_dst = ($urandom_range(0, 4) == 0);
      bad_at  = $urandom_range(0, 11);
      pkt_bytes.push_back(id);
      pkt_bytes.push_back(flags);
      // bit 0 of the flags selects little-endian length
      if (flags[0]) begin
        pkt_bytes.push_back(len[7:0]);
        pkt_bytes.push_back(len[15:8]);
      end else begin
        pkt_bytes.push_back(len[15:8]);
        pkt_bytes.push_back(len[7:0]);
      end
      cnt = (len == 0) ? $urandom_range(0, 8) : big ? $urandom_range(0, 6) : len;
      for (int k = 0; k < cnt; k++) begin
        if (id == IdInfoDst && k < 12) begin
          b = own_prefix[95 - 8 * k -: 8];
          if (bad_dst && k == bad_at) b ^= 8'($urandom_range(1, 255));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        pkt_bytes.push_back(b);
      end
      if (len == 0 || big) break;
    end
    if (kind >= 90) begin
      cut = $urandom_range(1, pkt_bytes.size());
      pkt_bytes = pkt_bytes[0:cut-1];
    end
  endtask

  initial begin
    logic en;
    rst_ni          = 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_ENABLE;
    cfg_data_i      <= '0;
    rx_if.valid     <= 1'b0;
    rx_if.data_byte <= '0;
    rx_if.last      <= 1'b0;
    own_prefix      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumSettings; p++) begin
      // settings: zero prefix, all-ones prefix, then random; one pass disabled
      en = (p != 3);
      if (p == 0) own_prefix = '0;
      else if (p == 1) own_prefix = '1;
      else own_prefix = {$urandom, $urandom, $urandom};
      write_reg(REG_ENABLE, CfgDataW'(en));
      write_reg(REG_PREFIX_HIGH, own_prefix[95:32]);
      write_reg(REG_PREFIX_LOW, CfgDataW'(own_prefix[31:0]));
      cfg_we_i <= 1'b0;
      phase_items = 0;

      if (p == 0) begin
        // bad magic on the second byte, packet ends there
        pkt_bytes = '{Magic[0], 8'h00};
        send_packet();
        // good header with extreme bytes, then a zero-length HEARTBEAT whose
        // end comes only from last
        pkt_bytes.delete();
        for (int i = 0; i < 4; i++) pkt_bytes.push_back(Magic[i]);
        for (int i = 4; i < 20; i++) pkt_bytes.push_back(i[0] ? 8'hff : 8'h00);
        pkt_bytes.push_back(IdHeartbeat);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        send_packet();
      end

      while (phase_items < PhaseItems) begin
        make_packet();
        send_packet();
      end
      rx_if.valid <= 1'b0;

      // drain before touching the registers again
      @(negedge clk_i);
      while (pending_cnt != 0) @(negedge clk_i);
      @(posedge clk_i);
    end

    // spare cycles at the end catch stray output
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
